### rtl/aaa_pkg.sv
package aaa_pkg;

    localparam int ADDR_W             = 32;
    localparam int OP_W               = 2;
    localparam int ALIGN_W            = 4;
    localparam int CFG_IDX_W          = 1;
    localparam int ARENA_SIZE_BITS_D  = 16;
    localparam int ARENA_BYTES_RESET  = 65536;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_GROW   = 2'd1,
        OP_SHRINK = 2'd2,
        OP_RESET  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARENA_BASE  = 1'b0,
        CFG_ARENA_BYTES = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic ok;
        logic moved;
    } t_flags;

endpackage

### rtl/aaa_calc.sv
module aaa_calc
    import aaa_pkg::*;
#(
    parameter int ARENA_SIZE_BITS = ARENA_SIZE_BITS_D,
    localparam int SW = ARENA_SIZE_BITS + 1
) (
    input  t_op                i_op,
    input  logic [ADDR_W-1:0]  i_blk,
    input  logic [ALIGN_W-1:0] i_lg,
    input  logic [SW-1:0]      i_size,
    input  logic [ADDR_W-1:0]  i_next_free,
    input  logic [ADDR_W-1:0]  i_last_start,
    input  logic               i_last_valid,
    input  logic [SW-1:0]      i_rem,
    input  logic [ADDR_W-1:0]  i_arena_base,
    input  logic [SW-1:0]      i_arena_bytes,
    output logic [ADDR_W-1:0]  o_next_free,
    output logic [ADDR_W-1:0]  o_last_start,
    output logic               o_last_valid,
    output logic [SW-1:0]      o_rem,
    output t_flags             o_flags,
    output logic [ADDR_W-1:0]  o_address,
    output logic [ADDR_W-1:0]  o_copy_from,
    output logic [SW-1:0]      o_copy_length
);

    localparam int PAD_W = (1 << ALIGN_W) - 1;
    localparam int NW    = ((SW > PAD_W) ? SW : PAD_W) + 1;
    localparam logic [SW-1:0] SIZE_MASK = {SW{1'b1}};

    logic [PAD_W-1:0]  mask;
    logic [ADDR_W:0]   aligned_full;
    logic [ADDR_W:0]   pad_full;
    logic [NW-1:0]     need;
    logic              bump_ok;
    logic [ADDR_W-1:0] bump_where;
    logic [ADDR_W-1:0] blk_len;
    logic              aligned;
    logic              match;
    logic [ADDR_W+1:0] rs_sum;
    logic [SW-1:0]     rs_rem;
    logic [ADDR_W-1:0] rs_next;
    logic [SW-1:0]     clen;

    always_comb begin
        mask         = PAD_W'((ADDR_W+1)'(1) << i_lg) - PAD_W'(1);
        aligned_full = ({1'b0, i_next_free} + (ADDR_W+1)'(mask)) & ~(ADDR_W+1)'(mask);
        pad_full     = aligned_full - {1'b0, i_next_free};
        need         = NW'(pad_full[PAD_W-1:0]) + NW'(i_size);
        bump_ok      = !(NW'(i_rem) < need);
        bump_where   = aligned_full[ADDR_W-1:0];

        blk_len  = i_next_free - i_last_start;
        aligned  = (i_last_start[PAD_W-1:0] & mask) == '0;
        match    = i_last_valid && (i_blk == i_last_start);

        rs_sum  = (ADDR_W+2)'(i_rem) + (ADDR_W+2)'(blk_len) - (ADDR_W+2)'(i_size);
        rs_rem  = (rs_sum > (ADDR_W+2)'(SIZE_MASK)) ? SIZE_MASK : rs_sum[SW-1:0];
        rs_next = i_last_start + ADDR_W'(i_size);

        clen = ((ADDR_W+1)'(blk_len) < (ADDR_W+1)'(i_size)) ? blk_len[SW-1:0] : i_size;
    end

    always_comb begin
        o_next_free   = i_next_free;
        o_last_start  = i_last_start;
        o_last_valid  = i_last_valid;
        o_rem         = i_rem;
        o_flags       = '0;
        o_address     = '0;
        o_copy_from   = '0;
        o_copy_length = '0;
        unique case (i_op)
            OP_ALLOC: begin
                if (bump_ok) begin
                    o_flags.ok   = 1'b1;
                    o_address    = bump_where;
                    o_last_start = bump_where;
                    o_last_valid = 1'b1;
                    o_next_free  = bump_where + ADDR_W'(i_size);
                    o_rem        = SW'(NW'(i_rem) - need);
                end
            end
            OP_GROW: begin
                if (match && !(i_rem < i_size)) begin
                    if (aligned) begin
                        o_flags.ok  = 1'b1;
                        o_address   = i_last_start;
                        o_rem       = rs_rem;
                        o_next_free = rs_next;
                    end else if (bump_ok) begin
                        o_flags.ok    = 1'b1;
                        o_flags.moved = 1'b1;
                        o_address     = bump_where;
                        o_copy_from   = i_last_start;
                        o_copy_length = clen;
                        o_last_start  = bump_where;
                        o_next_free   = bump_where + ADDR_W'(i_size);
                        o_rem         = SW'(NW'(i_rem) - need);
                    end
                end
            end
            OP_SHRINK: begin
                if (match && !((ADDR_W+1)'(blk_len) < (ADDR_W+1)'(i_size)) && aligned) begin
                    o_flags.ok  = 1'b1;
                    o_address   = i_last_start;
                    o_rem       = rs_rem;
                    o_next_free = rs_next;
                end
            end
            OP_RESET: begin
                o_flags.ok   = 1'b1;
                o_next_free  = i_arena_base;
                o_rem        = i_arena_bytes;
                o_last_start = '0;
                o_last_valid = 1'b0;
            end
        endcase
    end

endmodule

### rtl/aligned_arena_allocator_unit.sv
// Aligned bump allocator over one arena. One request (alloc, grow, shrink or
// arena reset) is accepted per clock; its result beat appears in the output
// register on the next cycle and the allocator state is updated at the same
// edge, so back-to-back requests see each other's effects. The output register
// holds a result while the sink stalls and the input is taken again as soon
// as that beat leaves. Write arena_base and arena_bytes, then issue a reset
// request before allocating: until then the arena is empty at address 0.
// A failed request returns ok low and leaves all state unchanged.
module aligned_arena_allocator_unit
    import aaa_pkg::*;
#(
    parameter int ARENA_SIZE_BITS = ARENA_SIZE_BITS_D,
    localparam int SW    = ARENA_SIZE_BITS + 1,
    localparam int IN_W  = ADDR_W + ALIGN_W + SW,
    localparam int IN_DW = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W = 2 * ADDR_W + SW,
    localparam int OUT_DW = ((OUT_W + 7) / 8) * 8,
    localparam int CFG_W = (SW > ADDR_W) ? SW : ADDR_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_DW-1:0]     i_s_tdata,   // block_address, align_log2, request_size
    input  logic [OP_W-1:0]      i_s_tuser,   // operation
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_DW-1:0]    o_m_tdata,   // address, copy_from, copy_length
    output logic [1:0]           o_m_tuser    // ok, moved
);

    logic [ADDR_W-1:0] r_arena_base;
    logic [SW-1:0]     r_arena_bytes;
    logic [ADDR_W-1:0] r_next_free,  n_next_free;
    logic [ADDR_W-1:0] r_last_start, n_last_start;
    logic              r_last_valid, n_last_valid;
    logic [SW-1:0]     r_rem,        n_rem;

    logic              r_out_valid;
    t_flags            r_out_flags,  n_out_flags;
    logic [ADDR_W-1:0] r_out_address, n_out_address;
    logic [ADDR_W-1:0] r_out_copy_from, n_out_copy_from;
    logic [SW-1:0]     r_out_copy_length, n_out_copy_length;

    t_op               s_op;
    logic              s_acc;

    assign s_op       = t_op'(i_s_tuser);
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_acc      = i_s_tvalid && o_s_tready;

    aaa_calc #(
        .ARENA_SIZE_BITS(ARENA_SIZE_BITS)
    ) u_calc (
        .i_op          (s_op),
        .i_blk         (i_s_tdata[ADDR_W-1:0]),
        .i_lg          (i_s_tdata[ADDR_W+ALIGN_W-1:ADDR_W]),
        .i_size        (i_s_tdata[IN_W-1:ADDR_W+ALIGN_W]),
        .i_next_free   (r_next_free),
        .i_last_start  (r_last_start),
        .i_last_valid  (r_last_valid),
        .i_rem         (r_rem),
        .i_arena_base  (r_arena_base),
        .i_arena_bytes (r_arena_bytes),
        .o_next_free   (n_next_free),
        .o_last_start  (n_last_start),
        .o_last_valid  (n_last_valid),
        .o_rem         (n_rem),
        .o_flags       (n_out_flags),
        .o_address     (n_out_address),
        .o_copy_from   (n_out_copy_from),
        .o_copy_length (n_out_copy_length)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_base  <= '0;
            r_arena_bytes <= SW'(ARENA_BYTES_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ARENA_BASE:  r_arena_base  <= i_cfg_data[ADDR_W-1:0];
                CFG_ARENA_BYTES: r_arena_bytes <= i_cfg_data[SW-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free  <= '0;
            r_last_start <= '0;
            r_last_valid <= 1'b0;
            r_rem        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s_acc) begin
                r_next_free  <= n_next_free;
                r_last_start <= n_last_start;
                r_last_valid <= n_last_valid;
                r_rem        <= n_rem;
                r_out_valid  <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_out_flags       <= n_out_flags;
            r_out_address     <= n_out_address;
            r_out_copy_from   <= n_out_copy_from;
            r_out_copy_length <= n_out_copy_length;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DW'({r_out_copy_length, r_out_copy_from, r_out_address});
    assign o_m_tuser  = {r_out_flags.moved, r_out_flags.ok};

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && s_op == OP_RESET |=> !r_last_valid && r_rem == $past(r_arena_bytes)
                                      && r_next_free == $past(r_arena_base))
        else $error("arena reset did not restore state");

    a_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !n_out_flags.ok |=> $stable(r_next_free) && $stable(r_rem)
                                     && $stable(r_last_start) && $stable(r_last_valid))
        else $error("failed request changed state");

    a_moved_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_flags.moved |-> r_out_flags.ok)
        else $error("moved without ok");

    a_alloc_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && s_op == OP_ALLOC && n_out_flags.ok |=> r_last_valid
                                                        && r_last_start == r_out_address)
        else $error("alloc did not record latest block");

endmodule
